// ===== sv/i2c_master_byte_engine_macros.svh =====
// assertion macros for the i2c master byte engine
// used by the rtl files that carry concurrent assertions, needs clk_i and rst_ni in scope
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/i2cm_pkg.sv =====
// shared types, constants and functions of the i2c master byte engine
// no dependencies
package i2cm_pkg;

  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned HP_W         = 16;
  localparam int unsigned CMP_W        = (COUNTER_BITS > HP_W) ? COUNTER_BITS : HP_W;
  localparam int unsigned PHASE_W      = 5;
  localparam logic [HP_W-1:0] HP_RESET = HP_W'(240);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } res_t;

  function automatic logic [PHASE_W-1:0] phase_count(cmd_e cmd);
    logic [PHASE_W-1:0] n;
    unique case (cmd)
      CMD_START: n = PHASE_W'(3);
      CMD_STOP:  n = PHASE_W'(2);
      default:   n = PHASE_W'(18);
    endcase
    return n;
  endfunction

endpackage

// ===== sv/i2cm_ifs.sv =====
// valid/ready channel interfaces: command items, result items, configuration writes
// depends on i2cm_pkg for widths
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       send_ack;
  logic       sda_in;
  modport source (output valid, kind, data_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, kind, data_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_seen;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, ack_seen,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data, ack_seen,
                  output ready);
endinterface

interface i2cm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [i2cm_pkg::HP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/i2c_master_byte_engine.sv =====
// top level of the i2c master byte engine: config register, sequencer and result register
// depends on i2cm_pkg, i2cm_ifs, i2cm_step and i2cm_out_reg
//
//  channel  dir  handshake      payload
//  cmd_i    in   valid/ready    kind, data_byte, send_ack, sda_in
//  res_o    out  valid/ready    scl_out, sda_out, busy_res, done_res, read_data, ack_seen
//  cfg_i    in   valid/ready    data = half_period_ticks
//
// one item per clock while res_o does not stall, one result per item, result valid the cycle after accept
// rate set by the single result register: cmd_i.ready = result slot free or being taken
// a stall on res_o holds cmd_i.ready low until the waiting result is taken
// reset: idle, both lines released, half period 240; cfg_i is always ready
module i2c_master_byte_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cm_cmd_if.sink      cmd_i,
  i2cm_res_if.source    res_o,
  i2cm_cfg_if.sink      cfg_i
);
  import i2cm_pkg::*;

  logic [HP_W-1:0] hp_q;
  logic            accept;
  logic            room;
  res_t            res_next;
  res_t            res_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= HP_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      hp_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = room;
  assign accept      = cmd_i.valid && room;

  i2cm_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (cmd_i.kind),
    .data_byte_i   (cmd_i.data_byte),
    .send_ack_i    (cmd_i.send_ack),
    .sda_in_i      (cmd_i.sda_in),
    .half_period_i (hp_q),
    .res_o         (res_next)
  );

  i2cm_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_next),
    .take_i  (res_o.ready),
    .valid_o (res_o.valid),
    .room_o  (room),
    .res_o   (res_cur)
  );

  assign res_o.scl_out   = res_cur.scl_out;
  assign res_o.sda_out   = res_cur.sda_out;
  assign res_o.busy_res  = res_cur.busy_res;
  assign res_o.done_res  = res_cur.done_res;
  assign res_o.read_data = res_cur.read_data;
  assign res_o.ack_seen  = res_cur.ack_seen;

endmodule

// ===== sv/i2cm_step.sv =====
// bus sequencer: command state, phase timing and line levels, one step per accepted item
// depends on i2cm_pkg and i2c_master_byte_engine_macros.svh
`include "i2c_master_byte_engine_macros.svh"

module i2cm_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [2:0]                kind_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      send_ack_i,
  input  logic                      sda_in_i,
  input  logic [i2cm_pkg::HP_W-1:0] half_period_i,
  output i2cm_pkg::res_t            res_o
);
  import i2cm_pkg::*;

  cmd_e                    cmd_q, cmd_d;
  logic [PHASE_W-1:0]      phase_q, phase_d;
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
  logic [7:0]              shift_q, shift_d;
  logic [7:0]              last_read_q, last_read_d;
  logic                    ack_send_q, ack_send_d;
  logic                    scl_q, scl_d;
  logic                    sda_q, sda_d;
  logic                    acks_q, acks_d;

  logic                    done;
  logic                    enter;
  cmd_e                    ecmd;
  logic [PHASE_W-1:0]      ep;
  logic [3:0]              slot;
  logic                    wr_slot;
  logic [COUNTER_BITS-1:0] cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_NONE;
      phase_q     <= '0;
      cnt_q       <= '0;
      shift_q     <= '0;
      last_read_q <= '0;
      ack_send_q  <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      acks_q      <= 1'b1;
    end else if (accept_i) begin
      cmd_q       <= cmd_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      last_read_q <= last_read_d;
      ack_send_q  <= ack_send_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      acks_q      <= acks_d;
    end
  end

  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    cmd_d       = cmd_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    last_read_d = last_read_q;
    ack_send_d  = ack_send_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    acks_d      = acks_q;
    done        = 1'b0;
    enter       = 1'b0;
    ecmd        = cmd_q;
    ep          = phase_q + 1'b1;

    if (cmd_q != CMD_NONE) begin
      if (CMP_W'(cnt_inc) >= CMP_W'(half_period_i) || cnt_inc == CNT_MAX) begin
        cnt_d = '0;
        if (ep >= phase_count(cmd_q)) begin
          if (cmd_q == CMD_WRITE || cmd_q == CMD_READ) scl_d = 1'b0;
          if (cmd_q == CMD_READ) last_read_d = shift_q;
          cmd_d   = CMD_NONE;
          phase_d = '0;
          done    = 1'b1;
        end else begin
          phase_d = ep;
          enter   = 1'b1;
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (kind_i >= CMD_START && kind_i <= CMD_READ) begin
      cmd_d   = cmd_e'(kind_i);
      ecmd    = cmd_e'(kind_i);
      phase_d = '0;
      ep      = '0;
      cnt_d   = '0;
      if (cmd_e'(kind_i) == CMD_WRITE) shift_d = data_byte_i;
      if (cmd_e'(kind_i) == CMD_READ) begin
        shift_d    = '0;
        ack_send_d = send_ack_i;
      end
      enter = 1'b1;
    end

    slot    = ep[4:1];
    wr_slot = (ecmd == CMD_WRITE && slot < 4'd8) || (ecmd == CMD_READ && slot == 4'd8);

    if (enter) begin
      unique case (ecmd)
        CMD_START: begin
          if (ep == '0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (ep == PHASE_W'(1)) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        CMD_STOP: begin
          if (ep == '0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        CMD_WRITE, CMD_READ: begin
          if (!ep[0]) begin
            if (ep != '0) scl_d = 1'b0;
            if (wr_slot) begin
              if (ecmd == CMD_WRITE) sda_d = shift_d[3'd7 - slot[2:0]];
              else                   sda_d = !ack_send_d;
            end else begin
              sda_d = 1'b1;
            end
          end else begin
            scl_d = 1'b1;
            if (!wr_slot) begin
              if (ecmd == CMD_READ) shift_d = {shift_d[6:0], sda_in_i};
              else                  acks_d  = sda_in_i;
            end
          end
        end
        default: ;
      endcase
    end

    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.busy_res  = (cmd_d != CMD_NONE);
    res_o.done_res  = done;
    res_o.read_data = last_read_d;
    res_o.ack_seen  = acks_d;
  end

  `I2CM_ASSERT(a_idle_clean, (cmd_q == CMD_NONE) |-> (phase_q == '0 && cnt_q == '0), "idle dirty")
  `I2CM_ASSERT(a_phase_range, (cmd_q != CMD_NONE) |-> (phase_q < phase_count(cmd_q)), "bad phase")
  `I2CM_ASSERT(a_start_sda, (cmd_q == CMD_START && phase_q != '0) |-> !sda_q, "sda high in start")
  `I2CM_ASSERT(a_done_idle, (accept_i && done) |=> (cmd_q == CMD_NONE), "busy after done")

endmodule

// ===== sv/i2cm_out_reg.sv =====
// result register between the sequencer and the result channel
// depends on i2cm_pkg
module i2cm_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  i2cm_pkg::res_t res_i,
  input  logic           take_i,
  output logic           valid_o,
  output logic           room_o,
  output i2cm_pkg::res_t res_o
);
  import i2cm_pkg::*;

  logic valid_q;
  res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign room_o  = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the i2c master byte engine: directed and random tick items
// depends on i2cm_pkg, the channel interfaces in i2cm_ifs and the rtl top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASE_TICKS = 60;
  localparam int unsigned PRESSURE_CYCLES = 400;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND} sda_pattern_e;

  class line_scoreboard;
    logic [HP_W-1:0]         half_period;
    logic [PHASE_W-1:0]      phase_idx;
    logic [COUNTER_BITS-1:0] tick_cnt;
    logic [3:0]              slot_cnt;
    logic [7:0]              shreg;
    cmd_e                    cur_cmd;
    logic                    ack_tx;
    logic                    scl;
    logic                    sda;
    logic                    ack_rx;
    logic [7:0]              last_rd;
    res_t                    expected_lines[$];
    int                      errors;

    function new();
      half_period = HP_RESET;
      phase_idx   = '0;
      tick_cnt    = '0;
      slot_cnt    = '0;
      shreg       = '0;
      cur_cmd     = CMD_NONE;
      ack_tx      = 1'b0;
      scl         = 1'b1;
      sda         = 1'b1;
      ack_rx      = 1'b1;
      last_rd     = '0;
      errors      = 0;
    endfunction

    function void set_half_period(logic [HP_W-1:0] v);
      half_period = v;
    endfunction

    function bit busy();
      return cur_cmd != CMD_NONE;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void enter_phase(logic sda_in);
      logic [3:0] slot;
      bit         drives;
      slot = phase_idx[4:1];
      case (cur_cmd)
        CMD_START: begin
          if (phase_idx == 0) begin
            sda = 1'b1;
            scl = 1'b1;
          end else if (phase_idx == 1) begin
            sda = 1'b0;
          end else begin
            scl = 1'b0;
          end
        end
        CMD_STOP: begin
          if (phase_idx == 0) begin
            sda = 1'b0;
            scl = 1'b1;
          end else begin
            sda = 1'b1;
          end
        end
        default: begin
          drives = (cur_cmd == CMD_WRITE && slot < 8) || (cur_cmd == CMD_READ && slot == 8);
          slot_cnt = slot;
          if (!phase_idx[0]) begin
            if (phase_idx != 0) scl = 1'b0;
            if (drives) sda = (cur_cmd == CMD_WRITE) ? shreg[7 - slot] : ~ack_tx;
            else sda = 1'b1;
          end else begin
            scl = 1'b1;
            if (!drives) begin
              if (cur_cmd == CMD_READ) shreg = {shreg[6:0], sda_in};
              else ack_rx = sda_in;
            end
          end
        end
      endcase
    endfunction

    function void note_tick(logic [2:0] kind, logic [7:0] data, logic ack, logic sda_in);
      res_t               r;
      logic               done;
      logic [PHASE_W-1:0] n_phases;
      done = 1'b0;
      if (cur_cmd != CMD_NONE) begin
        if (tick_cnt != CNT_MAX) tick_cnt++;
        if (tick_cnt >= half_period || tick_cnt == CNT_MAX) begin
          tick_cnt = '0;
          phase_idx++;
          n_phases = PHASE_W'((cur_cmd == CMD_START) ? 3 : (cur_cmd == CMD_STOP) ? 2 : 18);
          if (phase_idx >= n_phases) begin
            if (cur_cmd == CMD_WRITE || cur_cmd == CMD_READ) scl = 1'b0;
            if (cur_cmd == CMD_READ) last_rd = shreg;
            cur_cmd   = CMD_NONE;
            phase_idx = '0;
            slot_cnt  = '0;
            done      = 1'b1;
          end else begin
            enter_phase(sda_in);
          end
        end
      end else if (kind >= CMD_START && kind <= CMD_READ) begin
        cur_cmd   = cmd_e'(kind);
        phase_idx = '0;
        tick_cnt  = '0;
        slot_cnt  = '0;
        if (cur_cmd == CMD_WRITE) shreg = data;
        if (cur_cmd == CMD_READ) begin
          shreg  = '0;
          ack_tx = ack;
        end
        enter_phase(sda_in);
      end
      r.scl_out   = scl;
      r.sda_out   = sda;
      r.busy_res  = (cur_cmd != CMD_NONE);
      r.done_res  = done;
      r.read_data = last_rd;
      r.ack_seen  = ack_rx;
      expected_lines.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_lines.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
        return;
      end
      exp_r = expected_lines.pop_front();
      compare_field("scl_out", 8'(exp_r.scl_out), 8'(got.scl_out));
      compare_field("sda_out", 8'(exp_r.sda_out), 8'(got.sda_out));
      compare_field("busy_res", 8'(exp_r.busy_res), 8'(got.busy_res));
      compare_field("done_res", 8'(exp_r.done_res), 8'(got.done_res));
      compare_field("read_data", exp_r.read_data, got.read_data);
      compare_field("ack_seen", 8'(exp_r.ack_seen), 8'(got.ack_seen));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  i2cm_cmd_if cmd_if ();
  i2cm_res_if res_if ();
  i2cm_cfg_if cfg_if ();

  i2c_master_byte_engine DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  line_scoreboard sb = new();
  bit             no_idle;
  bit             hold_request;
  bit             bus_open;
  int unsigned    idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cmd_if.valid     = 1'b0;
    cmd_if.kind      = '0;
    cmd_if.data_byte = '0;
    cmd_if.send_ack  = 1'b0;
    cmd_if.sda_in    = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    res_if.ready     = 1'b0;
    no_idle          = 1'b0;
    hold_request     = 1'b0;
    bus_open         = 1'b0;
    idle_cycles      = 0;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{scl_out: res_if.scl_out, sda_out: res_if.sda_out,
                          busy_res: res_if.busy_res, done_res: res_if.done_res,
                          read_data: res_if.read_data, ack_seen: res_if.ack_seen});
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall = PRESSURE_CYCLES;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic logic pick_sda(sda_pattern_e pat);
    case (pat)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(logic [2:0] kind, logic [7:0] data, logic ack, logic sda);
    int gap;
    cmd_if.valid     <= 1'b1;
    cmd_if.kind      <= kind;
    cmd_if.data_byte <= data;
    cmd_if.send_ack  <= ack;
    cmd_if.sda_in    <= sda;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_tick(kind, data, ack, sda);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // issue one command and clock it through to the end, optionally with ignored commands
  task automatic run_command(logic [2:0] kind, logic [7:0] data, logic ack,
                             sda_pattern_e pat, bit noisy);
    send_tick(kind, data, ack, pick_sda(pat));
    while (sb.busy()) begin
      send_tick(noisy ? 3'($urandom_range(0, 7)) : CMD_NONE, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), pick_sda(pat));
    end
  endtask

  task automatic settle();
    while (sb.busy()) send_tick(CMD_NONE, '0, 1'b0, 1'($urandom_range(0, 1)));
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_half_period(logic [HP_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_half_period(v);
  endtask

  task automatic random_ticks(int unsigned n);
    logic [2:0]  kind;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      if (!sb.busy()) begin
        r = $urandom_range(0, 19);
        if (r < 4) begin
          kind = 3'($urandom_range(0, 7));
        end else if (!bus_open) begin
          kind = CMD_START;
        end else begin
          r = $urandom_range(0, 19);
          kind = (r < 9) ? CMD_WRITE : (r < 16) ? CMD_READ : CMD_STOP;
        end
        if (kind == CMD_START) bus_open = 1'b1;
        if (kind == CMD_STOP) bus_open = 1'b0;
      end else begin
        kind = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
      end
      send_tick(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    logic [HP_W-1:0] hp_list [4];
    @(posedge rst_ni);
    @(posedge clk_i);

    // reset half period
    run_command(CMD_STOP, '0, 1'b0, SDA_RAND, 1'b0);
    settle();

    write_half_period(HP_W'(1));
    run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_command(CMD_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b1);
    run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
    run_command(CMD_READ, 8'hA5, 1'b1, SDA_RAND, 1'b1);
    run_command(CMD_READ, 8'h3C, 1'b0, SDA_RAND, 1'b0);
    for (int k = CMD_READ + 1; k < 8; k++) send_tick(3'(k), 8'hFF, 1'b1, 1'b1);
    send_tick(CMD_NONE, 8'hFF, 1'b1, 1'b0);
    run_command(CMD_STOP, '0, 1'b1, SDA_RAND, 1'b1);
    run_command(CMD_START, 8'hFF, 1'b1, SDA_RAND, 1'b1);
    settle();

    // zero half period behaves as one tick per phase
    write_half_period(HP_W'(0));
    run_command(CMD_WRITE, 8'h81, 1'b0, SDA_RAND, 1'b1);
    run_command(CMD_READ, 8'h00, 1'b1, SDA_RAND, 1'b0);
    run_command(CMD_STOP, '0, 1'b0, SDA_RAND, 1'b0);
    settle();

    // longer half period, free-running on both sides
    no_idle = 1'b1;
    write_half_period(HP_W'(12));
    run_command(CMD_STOP, '0, 1'b0, SDA_RAND, 1'b1);
    settle();
    no_idle = 1'b0;

    hp_list[0] = HP_W'(2);
    hp_list[1] = HP_W'(1);
    hp_list[2] = HP_W'($urandom_range(3, 6));
    hp_list[3] = HP_W'(0);
    foreach (hp_list[p]) begin
      write_half_period(hp_list[p]);
      if (p == 0) hold_request = 1'b1;
      random_ticks(RANDOM_PHASE_TICKS);
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_ifs.sv
sv/i2cm_step.sv
sv/i2cm_out_reg.sv
sv/i2c_master_byte_engine.sv
dv/tb_top.sv
